[rtl/core/clnw_pkg.sv]
// Package for the character LCD nibble writer.
// Holds the channel payload types, the queue descriptor, op codes and
// strobe constants; no dependencies.
`default_nettype none

package clnw_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GOTO  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_INIT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CMD   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_INIT  = 2'd3
  } kind_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [7:0] target_col;
    logic [7:0] target_row;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  nibble;
    logic        reg_select;
    logic [15:0] delay_before_us;
    logic [12:0] delay_after_us;
    logic        last;
  } out_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       wrap;
  } desc_t;

  localparam int unsigned COL_W = 6;
  localparam int unsigned ROW_W = 3;

  localparam logic [COL_W-1:0] COLUMNS_RESET = 6'd16;
  localparam logic [ROW_W-1:0] ROWS_RESET    = 3'd2;
  localparam logic [ROW_W-1:0] MAX_ROWS      = 3'd4;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_4BIT      = 4'h2;

  localparam logic [7:0] LINE_BASE [4] = '{8'h00, 8'h40, 8'h20, 8'h60};

  localparam logic [15:0] DLY_POWERUP  = 16'd40000;
  localparam logic [12:0] DLY_WAKE1    = 13'd5000;
  localparam logic [12:0] DLY_WAKE2    = 13'd100;
  localparam logic [12:0] DLY_CMD      = 13'd50;
  localparam logic [12:0] DLY_CLEAR    = 13'd2000;

  localparam logic [2:0] CFG_REG_COLUMNS = 3'd0;
  localparam logic [2:0] CFG_REG_ROWS    = 3'd4;

endpackage

`default_nettype wire

[rtl/core/char_lcd_nibble_writer_top.sv]
// Character LCD nibble writer, top level: config port, front end, queue, sequencer.
// An accepted request passes the queue slot, descriptor register and output register
// before its first strobe. Throughput: one strobe per cycle while the output register
// is empty or popped, plus a load of each descriptor; items give 2, 4 or 12 strobes.
// Reset: cursor 0,0, columns 16, rows 2, queue and output register empty.
// Depends on clnw_pkg, clnw_cfg, clnw_front, clnw_queue, clnw_back.
`default_nettype none

module char_lcd_nibble_writer_top
  import clnw_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_data,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [COL_W-1:0] columns;
  logic [ROW_W-1:0] rows;
  logic             q_wr, q_rd, q_full, q_empty;
  desc_t            q_wdata, q_rdata;

  clnw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .columns (columns),
    .rows    (rows)
  );

  clnw_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .columns (columns),
    .rows    (rows),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  clnw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  clnw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_rd      (q_rd),
    .out_empty (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  assign full = q_full;

endmodule

`default_nettype wire

[rtl/core/clnw_cfg.sv]
// Configuration registers (columns, rows) behind the APB-style port.
// Depends on clnw_pkg.
`default_nettype none

module clnw_cfg
  import clnw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output logic      [COL_W-1:0] columns,
  output logic      [ROW_W-1:0] rows
);

  logic [COL_W-1:0] columns_r;
  logic [ROW_W-1:0] rows_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RESET;
      rows_r    <= ROWS_RESET;
    end else if (wr_en) begin
      if (paddr[2] == CFG_REG_ROWS[2]) begin
        rows_r <= pwdata[ROW_W-1:0];
      end else begin
        columns_r <= pwdata[COL_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == CFG_REG_ROWS[2]) begin
      prdata = {{(32-ROW_W){1'b0}}, rows_r};
    end else begin
      prdata = {{(32-COL_W){1'b0}}, columns_r};
    end
  end

  assign columns = columns_r;
  assign rows    = rows_r;

endmodule

`default_nettype wire

[rtl/core/clnw_front.sv]
// Front end: accepts requests, tracks the cursor and builds descriptors.
// Depends on clnw_pkg.
`default_nettype none

module clnw_front
  import clnw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire in_item_t         in_data,
  input  wire logic [COL_W-1:0] columns,
  input  wire logic [ROW_W-1:0] rows,
  input  wire logic             q_full,
  output logic                  q_wr,
  output desc_t                 q_wdata
);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [1:0]       row;
    logic [7:0]       cmd;
  } goto_t;

  logic [COL_W-1:0] cursor_col_r, cursor_col_nxt;
  logic [1:0]       cursor_row_r, cursor_row_nxt;
  logic [ROW_W-1:0] eff_rows;
  logic [COL_W-1:0] col_inc;
  logic [ROW_W-1:0] row_inc;
  goto_t            wrap_g;
  goto_t            goto_g;

  function automatic goto_t do_goto(input logic [7:0] x_in, input logic [7:0] y_in,
                                    input logic [COL_W-1:0] ncol,
                                    input logic [ROW_W-1:0] nrow);
    logic [7:0] x;
    logic [7:0] y;
    goto_t      g;
    x = x_in;
    y = y_in;
    if (x >= {{(8-COL_W){1'b0}}, ncol}) begin
      x = 8'd0;
      y = y + 8'd1;
    end
    if (y >= {{(8-ROW_W){1'b0}}, nrow}) begin
      y = 8'd0;
    end
    g.row = y[1:0];
    g.col = x[COL_W-1:0];
    g.cmd = CMD_SET_DDRAM | (LINE_BASE[y[1:0]] + x);
    return g;
  endfunction

  assign eff_rows = (rows > MAX_ROWS) ? MAX_ROWS : rows;
  assign col_inc  = cursor_col_r + {{(COL_W-1){1'b0}}, 1'b1};

  always_comb begin
    row_inc = {1'b0, cursor_row_r} + {{(ROW_W-1){1'b0}}, 1'b1};
    if (row_inc >= eff_rows) begin
      row_inc = '0;
    end
  end

  assign wrap_g = do_goto(8'd0, {{(8-ROW_W){1'b0}}, row_inc}, columns, eff_rows);
  assign goto_g = do_goto(in_data.target_col, in_data.target_row, columns, eff_rows);

  assign q_wr = push && !q_full;

  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    q_wdata.kind   = KIND_DATA;
    q_wdata.b0     = in_data.char_code;
    q_wdata.b1     = wrap_g.cmd;
    q_wdata.wrap   = 1'b0;
    case (in_data.op)
      OP_PUT: begin
        if (col_inc >= columns) begin
          q_wdata.wrap   = 1'b1;
          cursor_col_nxt = wrap_g.col;
          cursor_row_nxt = wrap_g.row;
        end else begin
          cursor_col_nxt = col_inc;
        end
      end
      OP_GOTO: begin
        q_wdata.kind   = KIND_CMD;
        q_wdata.b0     = goto_g.cmd;
        cursor_col_nxt = goto_g.col;
        cursor_row_nxt = goto_g.row;
      end
      OP_CLEAR: begin
        q_wdata.kind = KIND_CLEAR;
        q_wdata.b0   = CMD_CLEAR;
      end
      OP_INIT: begin
        q_wdata.kind   = KIND_INIT;
        cursor_col_nxt = '0;
        cursor_row_nxt = '0;
      end
      default: begin
        q_wdata.kind = KIND_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
    end else if (q_wr) begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/clnw_queue.sv]
// Short descriptor queue between the front end and the strobe sequencer.
// Depends on clnw_pkg.
`default_nettype none

module clnw_queue
  import clnw_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr,
  input  wire desc_t wdata,
  output logic       full,
  input  wire logic  rd,
  output desc_t      rdata,
  output logic       empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  desc_t            slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign rdata = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (wr && !rd) begin
        count_r <= count_r + CNT_W'(1);
      end else if (rd && !wr) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/clnw_back.sv]
// Back end: steps through each descriptor and emits one strobe per cycle
// into the output register while it is empty or popped. Depends on clnw_pkg.
`default_nettype none

module clnw_back
  import clnw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  wire desc_t q_rdata,
  output logic       q_rd,
  output logic       out_empty,
  input  wire logic  pop,
  output out_item_t  out_data
);

  desc_t      cur_r, cur_nxt;
  logic [3:0] step_r, step_nxt;
  logic       busy_r, busy_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;
  out_item_t  strobe;
  logic [7:0] sel_byte;
  logic       adv;

  function automatic out_item_t init_strobe(input logic [3:0] step);
    out_item_t s;
    s = '0;
    case (step)
      4'd0: begin
        s.nibble          = NIB_WAKE;
        s.delay_before_us = DLY_POWERUP;
        s.delay_after_us  = DLY_WAKE1;
      end
      4'd1: begin
        s.nibble         = NIB_WAKE;
        s.delay_after_us = DLY_WAKE2;
      end
      4'd2:  s.nibble = NIB_WAKE;
      4'd3:  s.nibble = NIB_4BIT;
      4'd4:  s.nibble = CMD_FUNC_SET[7:4];
      4'd5: begin
        s.nibble         = CMD_FUNC_SET[3:0];
        s.delay_after_us = DLY_CMD;
      end
      4'd6:  s.nibble = CMD_DISP_OFF[7:4];
      4'd7: begin
        s.nibble         = CMD_DISP_OFF[3:0];
        s.delay_after_us = DLY_CMD;
      end
      4'd8:  s.nibble = CMD_CLEAR[7:4];
      4'd9: begin
        s.nibble         = CMD_CLEAR[3:0];
        s.delay_after_us = DLY_CLEAR;
      end
      4'd10: s.nibble = CMD_DISP_ON[7:4];
      4'd11: begin
        s.nibble         = CMD_DISP_ON[3:0];
        s.delay_after_us = DLY_CMD;
        s.last           = 1'b1;
      end
      default: s = '0;
    endcase
    return s;
  endfunction

  assign sel_byte = step_r[1] ? cur_r.b1 : cur_r.b0;

  always_comb begin
    strobe        = '0;
    strobe.nibble = step_r[0] ? sel_byte[3:0] : sel_byte[7:4];
    case (cur_r.kind)
      KIND_DATA: begin
        strobe.reg_select     = !step_r[1];
        strobe.delay_after_us = step_r[0] ? DLY_CMD : '0;
        strobe.last           = step_r[0] && (step_r[1] || !cur_r.wrap);
      end
      KIND_CMD: begin
        strobe.delay_after_us = step_r[0] ? DLY_CMD : '0;
        strobe.last           = step_r[0];
      end
      KIND_CLEAR: begin
        strobe.delay_after_us = step_r[0] ? DLY_CLEAR : '0;
        strobe.last           = step_r[0];
      end
      KIND_INIT: strobe = init_strobe(step_r);
      default:   strobe = '0;
    endcase
  end

  assign adv  = !out_valid_r || pop;
  assign q_rd = !busy_r && !q_empty;

  always_comb begin
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !pop;
    out_data_nxt  = out_data_r;
    if (busy_r && adv) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = strobe;
      if (strobe.last) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end
    if (q_rd) begin
      cur_nxt  = q_rdata;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
